// ===== hdl/jfp_pkg.sv =====
// Shared codes, constants, cosine table and arithmetic helpers for the joystick frame parser.
package jfp_pkg;

	// Event codes reported with each result transaction
	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_START = 3'd1;
	localparam logic [2:0] EV_SHOOT = 3'd2;
	localparam logic [2:0] EV_INIT  = 3'd3;
	localparam logic [2:0] EV_WALK  = 3'd4;
	localparam logic [2:0] EV_FRAME = 3'd5;

	// Robot mode codes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_INIT  = 2'd1;
	localparam logic [1:0] MODE_WALK  = 2'd2;
	localparam logic [1:0] MODE_SHOOT = 2'd3;

	// Frame position codes: idle waits for sync, the rest name the next byte expected
	localparam logic [2:0] POS_IDLE    = 3'd0;
	localparam logic [2:0] POS_RADIUS1 = 3'd1;
	localparam logic [2:0] POS_ANGLE1  = 3'd2;
	localparam logic [2:0] POS_RADIUS2 = 3'd3;
	localparam logic [2:0] POS_ANGLE2  = 3'd4;

	// Command letters and sync reset value
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_B     = 8'h42;
	localparam logic [7:0] CHAR_C     = 8'h43;
	localparam logic [7:0] CHAR_D     = 8'h44;
	localparam logic [7:0] SYNC_RESET = 8'h55;

	// Angle steps per turn, and the index offset that turns cosine into sine
	localparam logic [6:0] ANGLE_STEPS = 7'd36;
	localparam logic [6:0] SIN_OFFSET  = 7'd27;

	// Largest stick magnitude, 255 * 16384 / 64
	localparam int STICK_MAX = 65280;

	// Cosine of index * 10 degrees in Q1.14
	localparam logic signed [15:0] COS_Q14 [36] = '{
		16'sd16384, 16'sd16135, 16'sd15396, 16'sd14189, 16'sd12551, 16'sd10531,
		16'sd8192,  16'sd5604,  16'sd2845,  16'sd0,     -16'sd2845, -16'sd5604,
		-16'sd8192, -16'sd10531, -16'sd12551, -16'sd14189, -16'sd15396, -16'sd16135,
		-16'sd16384, -16'sd16135, -16'sd15396, -16'sd14189, -16'sd12551, -16'sd10531,
		-16'sd8192, -16'sd5604, -16'sd2845, 16'sd0,     16'sd2845,  16'sd5604,
		16'sd8192,  16'sd10531, 16'sd12551, 16'sd14189, 16'sd15396, 16'sd16135
	};

	// Reduce a byte modulo 36: quotient by reciprocal 57/2048, exact for 0..255
	function automatic logic [5:0] angle_index(input logic [7:0] c);
		logic [13:0] prod;
		logic [2:0]  quot;
		logic [7:0]  rem;
		prod = 14'(c) * 14'd57;
		quot = prod[13:11];
		rem  = c - 8'(8'(quot) * 8'd36);
		return rem[5:0];
	endfunction

	// Table index of the sine for a cosine index
	function automatic logic [5:0] sin_index(input logic [5:0] k);
		logic [6:0] s;
		s = 7'(k) + SIN_OFFSET;
		if (s >= ANGLE_STEPS) begin
			s = s - ANGLE_STEPS;
		end
		return s[5:0];
	endfunction

	// Radius times table entry over 64, magnitude rounded half away from zero
	function automatic logic signed [16:0] scale(input logic [7:0] radius,
			input logic [5:0] idx);
		logic signed [15:0] t;
		logic [14:0]        mag;
		logic [21:0]        p;
		logic [15:0]        q;
		t   = COS_Q14[idx];
		mag = t[15] ? 15'(-t) : 15'(t);
		p   = 22'(radius) * 22'(mag) + 22'd32;
		q   = p[21:6];
		return t[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

endpackage

// ===== hdl/joystick_frame_parser.sv =====
// Joystick frame parser: byte stream to command events, robot mode and stick coordinates.
// A byte is held in the input register once accepted, then moves to the result register
// when the result slot is free; one result per byte.
// Throughput: one byte per cycle while out_ready holds; a stalled result blocks the input.
// Reset (arst_n low, asynchronous): idle frame position, idle mode, zero sticks,
// sync byte 0x55, no valid transaction in flight.
module joystick_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	// Byte input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// Result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_res,
	output logic [1:0]         robot_mode,
	output logic signed [16:0] stick1_x,
	output logic signed [16:0] stick1_y,
	output logic signed [16:0] stick2_x,
	output logic signed [16:0] stick2_y
);

	logic [7:0]         sync_q;
	logic               valid_s1;
	logic [7:0]         rx_s1;
	logic               out_valid_q;
	logic [2:0]         event_q;
	logic [2:0]         pos_q;
	logic [1:0]         mode_q;
	logic [7:0]         radius1_q;
	logic [5:0]         angle1_q;
	logic [7:0]         radius2_q;
	logic signed [16:0] x1_q, y1_q, x2_q, y2_q;

	logic               advance;
	logic [2:0]         event_d;
	logic [2:0]         pos_d;
	logic [1:0]         mode_d;
	logic [7:0]         radius1_d;
	logic [5:0]         angle1_d;
	logic [7:0]         radius2_d;
	logic [5:0]         angle2;
	logic signed [16:0] x1_d, y1_d, x2_d, y2_d;

	// Move the registered byte into the result stage when the result slot is free
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Hold the sync byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= jfp_pkg::SYNC_RESET;
		end else if (cfg_valid) begin
			sync_q <= cfg_data;
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_s1 <= rx_byte;
		end
	end

	// Decode the byte against the frame position and compute the next state
	always_comb begin
		event_d   = jfp_pkg::EV_NONE;
		pos_d     = pos_q;
		mode_d    = mode_q;
		radius1_d = radius1_q;
		angle1_d  = angle1_q;
		radius2_d = radius2_q;
		x1_d      = x1_q;
		y1_d      = y1_q;
		x2_d      = x2_q;
		y2_d      = y2_q;
		angle2    = jfp_pkg::angle_index(rx_s1);
		case (pos_q)
			jfp_pkg::POS_RADIUS1: begin
				radius1_d = rx_s1;
				pos_d     = jfp_pkg::POS_ANGLE1;
			end
			jfp_pkg::POS_ANGLE1: begin
				angle1_d = jfp_pkg::angle_index(rx_s1);
				pos_d    = jfp_pkg::POS_RADIUS2;
			end
			jfp_pkg::POS_RADIUS2: begin
				radius2_d = rx_s1;
				pos_d     = jfp_pkg::POS_ANGLE2;
			end
			jfp_pkg::POS_ANGLE2: begin
				x1_d    = jfp_pkg::scale(radius1_q, angle1_q);
				y1_d    = jfp_pkg::scale(radius1_q, jfp_pkg::sin_index(angle1_q));
				x2_d    = jfp_pkg::scale(radius2_q, angle2);
				y2_d    = jfp_pkg::scale(radius2_q, jfp_pkg::sin_index(angle2));
				pos_d   = jfp_pkg::POS_IDLE;
				event_d = jfp_pkg::EV_FRAME;
			end
			default: begin
				// Idle, and the unused codes: look for sync and command letters
				pos_d = (rx_s1 == sync_q) ? jfp_pkg::POS_RADIUS1 : jfp_pkg::POS_IDLE;
				if (rx_s1 == jfp_pkg::CHAR_A) begin
					event_d = jfp_pkg::EV_START;
				end else if (rx_s1 == jfp_pkg::CHAR_B) begin
					event_d = jfp_pkg::EV_SHOOT;
					mode_d  = jfp_pkg::MODE_SHOOT;
				end else if (rx_s1 == jfp_pkg::CHAR_C) begin
					event_d = jfp_pkg::EV_INIT;
					mode_d  = jfp_pkg::MODE_INIT;
				end else if (rx_s1 == jfp_pkg::CHAR_D) begin
					event_d = jfp_pkg::EV_WALK;
					mode_d  = jfp_pkg::MODE_WALK;
				end
			end
		endcase
	end

	// Advance parser state and the result register together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			event_q     <= jfp_pkg::EV_NONE;
			pos_q       <= jfp_pkg::POS_IDLE;
			mode_q      <= jfp_pkg::MODE_IDLE;
			radius1_q   <= '0;
			angle1_q    <= '0;
			radius2_q   <= '0;
			x1_q        <= '0;
			y1_q        <= '0;
			x2_q        <= '0;
			y2_q        <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				event_q     <= event_d;
				pos_q       <= pos_d;
				mode_q      <= mode_d;
				radius1_q   <= radius1_d;
				angle1_q    <= angle1_d;
				radius2_q   <= radius2_d;
				x1_q        <= x1_d;
				y1_q        <= y1_d;
				x2_q        <= x2_d;
				y2_q        <= y2_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Drive the result ports straight from the held state
	assign out_valid  = out_valid_q;
	assign event_res  = event_q;
	assign robot_mode = mode_q;
	assign stick1_x   = x1_q;
	assign stick1_y   = y1_q;
	assign stick2_x   = x2_q;
	assign stick2_y   = y2_q;

endmodule

// ===== hdl/jfp_checker.sv =====
// Port-level checker for the joystick frame parser, bound to the top level.
module jfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [2:0]         event_res,
	input logic [1:0]         robot_mode,
	input logic signed [16:0] stick1_x,
	input logic signed [16:0] stick1_y,
	input logic signed [16:0] stick2_x,
	input logic signed [16:0] stick2_y
);

	// A stalled result transaction keeps its event, stick1_x and stick2_y
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(stick1_x)
			&& $stable(stick2_y))
		else $error("stalled result changed");

	// An empty result slot never blocks the input
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with no pending result");

	// Mode commands show their new mode in the same transaction
	a_mode_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res != jfp_pkg::EV_INIT || robot_mode == jfp_pkg::MODE_INIT)
			&& (event_res != jfp_pkg::EV_WALK || robot_mode == jfp_pkg::MODE_WALK)
			&& (event_res != jfp_pkg::EV_SHOOT || robot_mode == jfp_pkg::MODE_SHOOT))
		else $error("mode does not match command event");

	// Event codes stay in range and stick1_x and stick2_y stay within the largest magnitude
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= jfp_pkg::EV_FRAME
			&& stick1_x <= 17'(jfp_pkg::STICK_MAX) && stick1_x >= -17'(jfp_pkg::STICK_MAX)
			&& stick2_y <= 17'(jfp_pkg::STICK_MAX) && stick2_y >= -17'(jfp_pkg::STICK_MAX))
		else $error("result out of range");

endmodule

bind joystick_frame_parser jfp_checker u_jfp_checker (.*);

// ===== tb/joystick_frame_parser_tb.sv =====
// Self-checking testbench for the joystick frame parser: directed table, then random byte streams.
module joystick_frame_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int ITEMS_PER_SET = 275;
	localparam int DRAIN_CYCLES  = 10;

	// Cosine of index * 10 degrees, Q1.14
	localparam int COS_TABLE [36] = '{
		16384, 16135, 15396, 14189, 12551, 10531, 8192, 5604, 2845, 0,
		-2845, -5604, -8192, -10531, -12551, -14189, -15396, -16135, -16384,
		-16135, -15396, -14189, -12551, -10531, -8192, -5604, -2845, 0,
		2845, 5604, 8192, 10531, 12551, 14189, 15396, 16135
	};

	typedef struct {
		logic [2:0]         ev;
		logic [1:0]         mode;
		logic signed [16:0] x1;
		logic signed [16:0] y1;
		logic signed [16:0] x2;
		logic signed [16:0] y2;
	} stick_result_t;

	typedef enum {ROW_TYPED, ROW_PREDICT, ROW_SYNC} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [7:0]    value;
		stick_result_t want;
	} stim_row_t;

	localparam stick_result_t IDLE_RESULT = '{jfp_pkg::EV_NONE, jfp_pkg::MODE_IDLE,
		17'sd0, 17'sd0, 17'sd0, 17'sd0};

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         event_res;
	logic [1:0]         robot_mode;
	logic signed [16:0] stick1_x;
	logic signed [16:0] stick1_y;
	logic signed [16:0] stick2_x;
	logic signed [16:0] stick2_y;

	// Parser model state
	logic [7:0]         sync_model;
	logic [2:0]         frame_pos;
	logic [1:0]         mode_model;
	int                 rad1;
	int                 ang1;
	int                 rad2;
	logic signed [16:0] held_x1, held_y1, held_x2, held_y2;

	stick_result_t expected_results [$];
	stim_row_t     directed_rows [$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	bit            in_burst = 0;
	bit            out_burst = 0;

	joystick_frame_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_res  (event_res),
		.robot_mode (robot_mode),
		.stick1_x   (stick1_x),
		.stick1_y   (stick1_y),
		.stick2_x   (stick2_x),
		.stick2_y   (stick2_y)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Radius times table entry over 64, magnitude rounded half away from zero
	function automatic logic signed [16:0] axis_value(input int radius, input int idx);
		int t;
		int mag;
		int p;
		t   = COS_TABLE[idx % 36];
		mag = (t < 0) ? -t : t;
		p   = (radius * mag + 32) >>> 6;
		return 17'((t < 0) ? -p : p);
	endfunction

	// Advance the parser model by one byte and return the result it reports
	function automatic stick_result_t parse_byte(input logic [7:0] c);
		logic [2:0] evc;
		int         ang2;
		evc = jfp_pkg::EV_NONE;
		case (frame_pos)
			jfp_pkg::POS_RADIUS1: begin
				rad1      = c;
				frame_pos = jfp_pkg::POS_ANGLE1;
			end
			jfp_pkg::POS_ANGLE1: begin
				ang1      = c % 36;
				frame_pos = jfp_pkg::POS_RADIUS2;
			end
			jfp_pkg::POS_RADIUS2: begin
				rad2      = c;
				frame_pos = jfp_pkg::POS_ANGLE2;
			end
			jfp_pkg::POS_ANGLE2: begin
				ang2      = c % 36;
				held_x1   = axis_value(rad1, ang1);
				held_y1   = axis_value(rad1, ang1 + 27);
				held_x2   = axis_value(rad2, ang2);
				held_y2   = axis_value(rad2, ang2 + 27);
				frame_pos = jfp_pkg::POS_IDLE;
				evc       = jfp_pkg::EV_FRAME;
			end
			default: begin
				// A sync byte that is also a letter both starts a frame and acts as a command
				frame_pos = (c == sync_model) ? jfp_pkg::POS_RADIUS1 : jfp_pkg::POS_IDLE;
				case (c)
					jfp_pkg::CHAR_A: evc = jfp_pkg::EV_START;
					jfp_pkg::CHAR_B: begin
						evc        = jfp_pkg::EV_SHOOT;
						mode_model = jfp_pkg::MODE_SHOOT;
					end
					jfp_pkg::CHAR_C: begin
						evc        = jfp_pkg::EV_INIT;
						mode_model = jfp_pkg::MODE_INIT;
					end
					jfp_pkg::CHAR_D: begin
						evc        = jfp_pkg::EV_WALK;
						mode_model = jfp_pkg::MODE_WALK;
					end
					default: ;
				endcase
			end
		endcase
		return '{evc, mode_model, held_x1, held_y1, held_x2, held_y2};
	endfunction

	// Radius with the extremes drawn often
	function automatic logic [7:0] random_radius();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) return 8'h00;
		if (pick == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Send one byte after a random gap; queue its expected result at acceptance
	task automatic send_byte(input logic [7:0] v, input bit typed = 1'b0,
			input stick_result_t want = IDLE_RESULT);
		int            gap;
		stick_result_t predicted;
		if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = parse_byte(v);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Hold the sender until every expected result has arrived
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Write the sync byte while the parser is idle
	task automatic write_sync(input logic [7:0] v);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		sync_model  = v;
	endtask

	// Random stream: mostly complete frames, some letters, noise and cut-short frames
	task automatic run_random_set(input int count);
		int sent;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				send_byte(sync_model);
				send_byte(random_radius());
				send_byte(8'($urandom_range(0, 255)));
				send_byte(random_radius());
				sent += 4;
				if ($urandom_range(0, 9) != 0) begin
					send_byte(8'($urandom_range(0, 255)));
					sent++;
				end
			end else if (pick <= 7) begin
				send_byte(8'(jfp_pkg::CHAR_A + $urandom_range(0, 3)));
				sent++;
			end else begin
				send_byte(8'($urandom_range(0, 255)));
				sent++;
			end
			if ($urandom_range(0, 99) == 0) wait_drain();
		end
	endtask

	// Result side: random stall before each transaction
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
			stall = out_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		stick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no expectation pending");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("event_res", want.ev, event_res);
				check_field("robot_mode", want.mode, robot_mode);
				check_field("stick1_x", want.x1, stick1_x);
				check_field("stick1_y", want.y1, stick1_y);
				check_field("stick2_x", want.x2, stick2_x);
				check_field("stick2_y", want.y2, stick2_y);
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [7:0] sync_plan [6];
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 8'h00;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;

		sync_model = jfp_pkg::SYNC_RESET;
		frame_pos  = jfp_pkg::POS_IDLE;
		mode_model = jfp_pkg::MODE_IDLE;
		rad1 = 0;
		ang1 = 0;
		rad2 = 0;
		held_x1 = '0;
		held_y1 = '0;
		held_x2 = '0;
		held_y2 = '0;

		// Commands after reset, then frames at the extremes and letters as frame data
		directed_rows.push_back('{ROW_TYPED, 8'h00, IDLE_RESULT});
		directed_rows.push_back('{ROW_TYPED, jfp_pkg::CHAR_A,
			'{jfp_pkg::EV_START, jfp_pkg::MODE_IDLE, 17'sd0, 17'sd0, 17'sd0, 17'sd0}});
		directed_rows.push_back('{ROW_TYPED, jfp_pkg::CHAR_B,
			'{jfp_pkg::EV_SHOOT, jfp_pkg::MODE_SHOOT, 17'sd0, 17'sd0, 17'sd0, 17'sd0}});
		directed_rows.push_back('{ROW_TYPED, jfp_pkg::CHAR_C,
			'{jfp_pkg::EV_INIT, jfp_pkg::MODE_INIT, 17'sd0, 17'sd0, 17'sd0, 17'sd0}});
		directed_rows.push_back('{ROW_TYPED, jfp_pkg::CHAR_D,
			'{jfp_pkg::EV_WALK, jfp_pkg::MODE_WALK, 17'sd0, 17'sd0, 17'sd0, 17'sd0}});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::SYNC_RESET, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'hFF, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'h00, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'hFF, IDLE_RESULT});
		directed_rows.push_back('{ROW_TYPED, 8'h09,
			'{jfp_pkg::EV_FRAME, jfp_pkg::MODE_WALK,
			17'sd65280, 17'sd0, 17'sd0, 17'sd65280}});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::SYNC_RESET, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::CHAR_A, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::CHAR_B, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::CHAR_C, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'hFF, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::SYNC_RESET, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'hFF, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'h12, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'hFF, IDLE_RESULT});
		directed_rows.push_back('{ROW_TYPED, 8'h1B,
			'{jfp_pkg::EV_FRAME, jfp_pkg::MODE_WALK,
			-17'sd65280, 17'sd0, 17'sd0, -17'sd65280}});
		// Sync equal to a letter: the command and the frame start both take effect
		directed_rows.push_back('{ROW_SYNC, jfp_pkg::CHAR_C, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::CHAR_C, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, jfp_pkg::CHAR_D, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'h80, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'h01, IDLE_RESULT});
		directed_rows.push_back('{ROW_PREDICT, 8'h23, IDLE_RESULT});

		// Hold reset low, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_SYNC:    write_sync(directed_rows[i].value);
				ROW_TYPED:   send_byte(directed_rows[i].value, 1'b1, directed_rows[i].want);
				default:     send_byte(directed_rows[i].value);
			endcase
		end

		// Random sets, one sync value each
		sync_plan = '{8'h00, 8'hFF, jfp_pkg::CHAR_A, jfp_pkg::CHAR_D, 8'h00,
			jfp_pkg::SYNC_RESET};
		sync_plan[4] = 8'($urandom_range(0, 255));
		foreach (sync_plan[i]) begin
			write_sync(sync_plan[i]);
			run_random_set(ITEMS_PER_SET);
		end

		// Drain and let the pipeline settle
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/jfp_pkg.sv
hdl/joystick_frame_parser.sv
hdl/jfp_checker.sv
tb/joystick_frame_parser_tb.sv
